FILE: rtl/edt_pkg.sv
// ----------------------------------------------------------------------------
// edt_pkg
// Shared types and constants of the earliest-departure-time packet pacer.
// ----------------------------------------------------------------------------
package edt_pkg;

  localparam int IDX_W  = 12;  // client index
  localparam int LEN_W  = 16;  // packet length in bytes
  localparam int TS_W   = 63;  // timestamps in ns
  localparam int RATE_W = 34;  // rate in bytes per second
  localparam int HOR_W  = 40;  // upload horizon in ns
  localparam int VERD_W = 2;

  // length * 1e9 stays below 2^46
  localparam int NSEC_W = 30;
  localparam int NUM_W  = 46;
  localparam int CNT_W  = $clog2(NUM_W);

  localparam logic [NSEC_W-1:0] NS_PER_SECOND = 30'd1000000000;
  localparam logic [TS_W-1:0]   TS_MAX        = '1;

  typedef enum logic [VERD_W-1:0] {
    VERDICT_UNSTAMPED = 2'd0,
    VERDICT_STAMPED   = 2'd1,
    VERDICT_DROP      = 2'd2
  } verdict_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_BASE,
    ST_SUM,
    ST_CHECK
  } state_e;

endpackage

FILE: rtl/edt_ram.sv
// ----------------------------------------------------------------------------
// edt_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module edt_ram #(
  parameter int WIDTH = 63,
  parameter int DEPTH = 8192
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/edt_packet_pacer.sv
// ----------------------------------------------------------------------------
// edt_packet_pacer
// Per-client earliest-departure-time pacer. A request with a rate of zero
// returns "pass unstamped" in the cycle after it is taken and busy_o stays
// low. A shaped request runs from start_i to done_o through the length * 1e9
// product, a bit-serial restoring divider (one quotient bit per cycle, the
// client index reduced modulo CLIENTS one bit per cycle alongside), then max,
// saturating add and horizon check (uploads only); the next request is taken
// in the cycle done_o is high. The last departure times of both directions
// live in one RAM addressed by direction and client. After reset the block
// sweeps that RAM to zero, one entry a cycle, all 2 * 2^ceil(log2(CLIENTS))
// entries (8192 at the default) with busy_o high. done_o is a one-cycle
// strobe; the receiver cannot stall it.
// ----------------------------------------------------------------------------
module edt_packet_pacer #(
  parameter int CLIENTS = 4096
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic [edt_pkg::IDX_W-1:0]     client_index_i,
  input  logic                          is_upload_i,
  input  logic [edt_pkg::LEN_W-1:0]     packet_length_i,
  input  logic [edt_pkg::TS_W-1:0]      now_ns_i,
  input  logic [edt_pkg::RATE_W-1:0]    rate_bytes_per_sec_i,
  input  logic [edt_pkg::HOR_W-1:0]     horizon_ns_i,
  output logic                          done_o,
  output logic [edt_pkg::VERD_W-1:0]    verdict_o,
  output logic [edt_pkg::TS_W-1:0]      departure_ns_o
);

  import edt_pkg::*;

  localparam int IW    = (CLIENTS > 1) ? $clog2(CLIENTS) : 1;
  localparam int AW    = IW + 1;
  localparam int DEPTH = 2 ** AW;
  localparam logic [IW:0] CLIENTS_C = (IW + 1)'(CLIENTS);

  state_e state_q, state_d;

  logic [CNT_W-1:0]  cnt_q;
  logic [AW-1:0]     clr_addr_q;
  logic              done_q;
  verdict_e          verdict_q;
  logic [TS_W-1:0]   departure_q;

  // captured request
  logic              up_q;
  logic [IDX_W-1:0]  idx_sh_q;
  logic [LEN_W-1:0]  len_q;
  logic [TS_W-1:0]   now_q;
  logic [RATE_W-1:0] rate_q;
  logic [HOR_W-1:0]  horizon_q;

  logic [IW-1:0]     cidx_q;   // client index modulo CLIENTS
  logic [NUM_W-1:0]  num_q;    // dividend, then quotient
  logic [RATE_W-1:0] rem_q;
  logic [TS_W-1:0]   base_q;
  logic [TS_W-1:0]   next_q;

  logic              busy;
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [TS_W-1:0]   ram_wdata;
  logic [TS_W-1:0]   ram_rdata;

  logic              accept;
  logic              unshaped;
  logic              drop;
  logic              done_d;
  verdict_e          verdict_d;
  logic [TS_W-1:0]   departure_d;

  logic [IW:0]       mod_trial;
  logic [IW-1:0]     mod_next;
  logic [RATE_W:0]   div_trial;
  logic              div_ge;
  logic [RATE_W:0]   div_diff;
  logic [TS_W:0]     sum;
  logic [TS_W-1:0]   lead;

  assign accept   = start_i && !busy;
  assign unshaped = (rate_bytes_per_sec_i == '0);

  // one bit of the index modulo CLIENTS
  assign mod_trial = {cidx_q, idx_sh_q[IDX_W-1]};
  assign mod_next  = (mod_trial >= CLIENTS_C) ? IW'(mod_trial - CLIENTS_C) : mod_trial[IW-1:0];

  // one quotient bit of the restoring divider
  assign div_trial = {rem_q, num_q[NUM_W-1]};
  assign div_ge    = (div_trial >= {1'b0, rate_q});
  assign div_diff  = div_trial - {1'b0, rate_q};

  assign sum  = {1'b0, base_q} + (TS_W + 1)'(num_q);
  assign lead = next_q - now_q;
  assign drop = up_q && (lead > TS_W'(horizon_q));

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (clr_addr_q == '1) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept && !unshaped) state_d = ST_MUL;
      end
      ST_MUL: begin
        state_d = ST_DIV;
      end
      ST_DIV: begin
        if (cnt_q == CNT_W'(NUM_W - 1)) state_d = ST_BASE;
      end
      ST_BASE: begin
        state_d = ST_SUM;
      end
      ST_SUM: begin
        state_d = ST_CHECK;
      end
      ST_CHECK: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

  // outputs of the state machine
  always_comb begin
    busy        = 1'b1;
    ram_we      = 1'b0;
    ram_waddr   = {up_q, cidx_q};
    ram_wdata   = next_q;
    done_d      = 1'b0;
    verdict_d   = VERDICT_UNSTAMPED;
    departure_d = '0;
    unique case (state_q)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr_q;
        ram_wdata = '0;
      end
      ST_IDLE: begin
        busy   = 1'b0;
        done_d = accept && unshaped;
      end
      ST_CHECK: begin
        ram_we      = !drop;
        done_d      = 1'b1;
        verdict_d   = drop ? VERDICT_DROP : VERDICT_STAMPED;
        departure_d = drop ? '0 : next_q;
      end
      ST_MUL, ST_DIV, ST_BASE, ST_SUM: begin
        busy = 1'b1;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_CLEAR;
      cnt_q      <= '0;
      clr_addr_q <= '0;
      done_q     <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
      if (state_q == ST_CLEAR) begin
        clr_addr_q <= clr_addr_q + 1'b1;
      end
      if (state_q == ST_DIV) begin
        cnt_q <= cnt_q + 1'b1;
      end else begin
        cnt_q <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (done_d) begin
      verdict_q   <= verdict_d;
      departure_q <= departure_d;
    end
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          up_q      <= is_upload_i;
          idx_sh_q  <= client_index_i;
          len_q     <= packet_length_i;
          now_q     <= now_ns_i;
          rate_q    <= rate_bytes_per_sec_i;
          horizon_q <= horizon_ns_i;
          cidx_q    <= '0;
          rem_q     <= '0;
        end
      end
      ST_MUL: begin
        num_q <= NUM_W'(len_q) * NUM_W'(NS_PER_SECOND);
      end
      ST_DIV: begin
        rem_q <= div_ge ? div_diff[RATE_W-1:0] : div_trial[RATE_W-1:0];
        num_q <= {num_q[NUM_W-2:0], div_ge};
        // index reduction rides along the first index-width steps
        if (cnt_q < CNT_W'(IDX_W)) begin
          cidx_q   <= mod_next;
          idx_sh_q <= {idx_sh_q[IDX_W-2:0], 1'b0};
        end
      end
      ST_BASE: begin
        base_q <= (now_q > ram_rdata) ? now_q : ram_rdata;
      end
      ST_SUM: begin
        next_q <= sum[TS_W] ? TS_MAX : sum[TS_W-1:0];
      end
      ST_CLEAR, ST_CHECK: begin
        base_q <= base_q;
      end
      default: begin
        base_q <= base_q;
      end
    endcase
  end

  edt_ram #(
    .WIDTH (TS_W),
    .DEPTH (DEPTH)
  ) u_last_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i ({up_q, cidx_q}),
    .rdata_o (ram_rdata)
  );

  assign busy_o         = busy;
  assign done_o         = done_q;
  assign verdict_o      = verdict_q;
  assign departure_ns_o = departure_q;

`ifndef SYNTHESIS
  a_check_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CHECK) |=> done_o)
    else $error("no result after horizon check");

  a_departure_only_stamped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (verdict_o != VERDICT_STAMPED)) |-> (departure_ns_o == '0))
    else $error("departure on unstamped or dropped result");

  a_shaped_holds_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && (rate_bytes_per_sec_i != '0)) |=> busy_o)
    else $error("shaped request did not raise busy");

  a_no_result_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR) |-> (!done_o && !busy_o == 1'b0))
    else $error("result or idle during clearing pass");

  a_write_only_on_pass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ram_we && (state_q != ST_CLEAR)) |=> (done_o && (verdict_o == VERDICT_STAMPED)))
    else $error("store updated without a stamped result");
`endif

endmodule
